// ===== src/lfuc_pkg.sv =====
// ----------------------------------------------------------------------------
// lfuc_pkg: shared types and constants for the LFU cache
// Sizes, entry record, store write request and sequencer codes.
// ----------------------------------------------------------------------------
`default_nettype none

package lfuc_pkg;

    localparam int CAPACITY    = 16;
    localparam int COUNT_WIDTH = 16;

    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OCC_W  = $clog2(CAPACITY + 1);
    localparam int KEY_W  = 32;
    localparam int VAL_W  = 32;
    localparam int CFG_W  = 5;
    localparam int CMP_W  = (OCC_W > CFG_W) ? OCC_W : CFG_W;

    localparam logic [CFG_W-1:0]       CFG_RESET = CFG_W'(16);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [VAL_W-1:0]       MISS_VALUE = {VAL_W{1'b1}};

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    typedef struct packed {
        logic                   valid;
        logic [KEY_W-1:0]       key;
        logic [VAL_W-1:0]       value;
        logic [COUNT_WIDTH-1:0] count;
        logic [IDX_W-1:0]       rank;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        entry_t           data;
    } store_wr_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE
    } state_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_TOUCH,
        OP_INSERT
    } op_t;

endpackage

`default_nettype wire

// ===== src/lfuc_store.sv =====
// ----------------------------------------------------------------------------
// lfuc_store: entry storage
// Register file of CAPACITY entries, one read and one write address.
// ----------------------------------------------------------------------------
`default_nettype none

module lfuc_store
    import lfuc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [IDX_W-1:0] rd_idx,
    output entry_t                rd,
    input  wire store_wr_t        wr
);

    logic                   valid_reg [CAPACITY];
    logic [KEY_W-1:0]       key_reg   [CAPACITY];
    logic [VAL_W-1:0]       value_reg [CAPACITY];
    logic [COUNT_WIDTH-1:0] count_reg [CAPACITY];
    logic [IDX_W-1:0]       rank_reg  [CAPACITY];

    // valid marks cleared at reset; payload undefined until written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (wr.en)
        begin
            valid_reg[wr.idx] <= wr.data.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            key_reg[wr.idx]   <= wr.data.key;
            value_reg[wr.idx] <= wr.data.value;
            count_reg[wr.idx] <= wr.data.count;
            rank_reg[wr.idx]  <= wr.data.rank;
        end
    end

    assign rd.valid = valid_reg[rd_idx];
    assign rd.key   = key_reg[rd_idx];
    assign rd.value = value_reg[rd_idx];
    assign rd.count = count_reg[rd_idx];
    assign rd.rank  = rank_reg[rd_idx];

endmodule

`default_nettype wire

// ===== src/lfuc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lfuc_ctrl: request sequencer and scan unit
// Scans all entries once for lookup/victim, then, if anything changes, once to rewrite them.
// ----------------------------------------------------------------------------
`default_nettype none

module lfuc_ctrl
    import lfuc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic             s_kind,
    input  wire logic [KEY_W-1:0] s_key,
    input  wire logic [VAL_W-1:0] s_value,
    input  wire logic [CFG_W-1:0] cfg_limit,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic                  m_hit,
    output logic [VAL_W-1:0]      m_value,
    output logic [IDX_W-1:0]      rd_idx,
    input  wire entry_t           rd,
    output store_wr_t             wr
);

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic                   req_kind_reg, req_kind_next;
    logic [KEY_W-1:0]       req_key_reg, req_key_next;
    logic [VAL_W-1:0]       req_value_reg, req_value_next;
    logic                   hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]       hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]       hit_rank_reg, hit_rank_next;
    logic [VAL_W-1:0]       hit_value_reg, hit_value_next;
    logic                   free_found_reg, free_found_next;
    logic [IDX_W-1:0]       free_idx_reg, free_idx_next;
    logic                   vic_found_reg, vic_found_next;
    logic [IDX_W-1:0]       vic_idx_reg, vic_idx_next;
    logic [COUNT_WIDTH-1:0] vic_cnt_reg, vic_cnt_next;
    logic [IDX_W-1:0]       vic_rank_reg, vic_rank_next;
    logic [IDX_W-1:0]       tgt_idx_reg, tgt_idx_next;
    logic                   evict_reg, evict_next;
    logic [OCC_W-1:0]       occ_reg, occ_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_hit_reg, out_hit_next;
    logic [VAL_W-1:0]       out_value_reg, out_value_next;

    logic             last;
    logic             stall;
    logic             full;
    logic             better;
    logic [CMP_W-1:0] limit;
    op_t              dec_op;
    logic [IDX_W-1:0] dec_tgt;
    logic             dec_evict;

    assign last   = (idx_reg == IDX_W'(CAPACITY - 1));
    assign rd_idx = idx_reg;

    // a get result may only be loaded once the output slot is free
    assign stall = (req_kind_reg == KIND_GET) && out_valid_reg && !m_ready;

    // victim compare: victim is lowest count, then oldest rank
    assign better = rd.valid && (!vic_found_reg || (rd.count < vic_cnt_reg) ||
                    ((rd.count == vic_cnt_reg) && (rd.rank > vic_rank_reg)));

    always_comb
    begin
        limit = (CMP_W'(cfg_limit) < CMP_W'(CAPACITY)) ? CMP_W'(cfg_limit)
                                                       : CMP_W'(CAPACITY);
        full  = (CMP_W'(occ_reg) >= limit);
    end

    // decision taken after the lookup scan
    always_comb
    begin
        dec_op    = OP_NONE;
        dec_tgt   = hit_idx_reg;
        dec_evict = 1'b0;
        if (req_kind_reg == KIND_GET)
        begin
            if (hit_found_reg)
            begin
                dec_op = OP_TOUCH;
            end
        end
        else if (cfg_limit != '0)
        begin
            if (hit_found_reg)
            begin
                dec_op = OP_TOUCH;
            end
            else if (full && vic_found_reg)
            begin
                dec_op    = OP_INSERT;
                dec_evict = 1'b1;
                dec_tgt   = (free_found_reg && (free_idx_reg < vic_idx_reg)) ? free_idx_reg
                                                                           : vic_idx_reg;
            end
            else if (free_found_reg)
            begin
                dec_op  = OP_INSERT;
                dec_tgt = free_idx_reg;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!stall)
                begin
                    state_next = (dec_op == OP_NONE) ? ST_IDLE : ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        s_ready         = 1'b0;
        wr.en           = 1'b0;
        wr.idx          = idx_reg;
        wr.data         = rd;
        idx_next        = idx_reg;
        op_next         = op_reg;
        req_kind_next   = req_kind_reg;
        req_key_next    = req_key_reg;
        req_value_next  = req_value_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_rank_next   = hit_rank_reg;
        hit_value_next  = hit_value_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        vic_found_next  = vic_found_reg;
        vic_idx_next    = vic_idx_reg;
        vic_cnt_next    = vic_cnt_reg;
        vic_rank_next   = vic_rank_reg;
        tgt_idx_next    = tgt_idx_reg;
        evict_next      = evict_reg;
        occ_next        = occ_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_hit_next    = out_hit_reg;
        out_value_next  = out_value_reg;

        case (state_reg)
            ST_IDLE:
            begin
                s_ready = 1'b1;
                if (s_valid)
                begin
                    req_kind_next   = s_kind;
                    req_key_next    = s_key;
                    req_value_next  = s_value;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    vic_found_next  = 1'b0;
                    idx_next        = '0;
                end
            end
            ST_SCAN:
            begin
                if (rd.valid && !hit_found_reg && (rd.key == req_key_reg))
                begin
                    hit_found_next = 1'b1;
                    hit_idx_next   = idx_reg;
                    hit_rank_next  = rd.rank;
                    hit_value_next = rd.value;
                end
                if (!rd.valid && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = idx_reg;
                end
                if (better)
                begin
                    vic_found_next = 1'b1;
                    vic_idx_next   = idx_reg;
                    vic_cnt_next   = rd.count;
                    vic_rank_next  = rd.rank;
                end
                idx_next = last ? '0 : idx_reg + 1'b1;
            end
            ST_DECIDE:
            begin
                if (!stall)
                begin
                    op_next      = dec_op;
                    tgt_idx_next = dec_tgt;
                    evict_next   = dec_evict;
                    if (req_kind_reg == KIND_GET)
                    begin
                        out_valid_next = 1'b1;
                        out_hit_next   = hit_found_reg;
                        out_value_next = hit_found_reg ? hit_value_reg : MISS_VALUE;
                    end
                    if ((dec_op == OP_INSERT) && !dec_evict)
                    begin
                        occ_next = occ_reg + 1'b1;
                    end
                end
                idx_next = '0;
            end
            ST_UPDATE:
            begin
                wr.en = 1'b1;
                case (op_reg)
                    OP_TOUCH:
                    begin
                        if (idx_reg == tgt_idx_reg)
                        begin
                            wr.data.rank = '0;
                            if (rd.count != COUNT_MAX)
                            begin
                                wr.data.count = rd.count + 1'b1;
                            end
                            if (req_kind_reg == KIND_PUT)
                            begin
                                wr.data.value = req_value_reg;
                            end
                        end
                        else if (rd.valid && (rd.rank < hit_rank_reg))
                        begin
                            wr.data.rank = rd.rank + 1'b1;
                        end
                    end
                    OP_INSERT:
                    begin
                        if (idx_reg == tgt_idx_reg)
                        begin
                            wr.data.valid = 1'b1;
                            wr.data.key   = req_key_reg;
                            wr.data.value = req_value_reg;
                            wr.data.count = COUNT_WIDTH'(1);
                            wr.data.rank  = '0;
                        end
                        else if (evict_reg && (idx_reg == vic_idx_reg))
                        begin
                            wr.data.valid = 1'b0;
                        end
                        else if (rd.valid && !(evict_reg && (rd.rank > vic_rank_reg)))
                        begin
                            // entries younger than the victim (all entries when none is evicted) age by one
                            wr.data.rank = rd.rank + 1'b1;
                        end
                    end
                    default:
                    begin
                        wr.en = 1'b0;
                    end
                endcase
                idx_next = last ? '0 : idx_reg + 1'b1;
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_NONE;
            idx_reg       <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            idx_reg       <= idx_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_kind_reg   <= req_kind_next;
        req_key_reg    <= req_key_next;
        req_value_reg  <= req_value_next;
        hit_found_reg  <= hit_found_next;
        hit_idx_reg    <= hit_idx_next;
        hit_rank_reg   <= hit_rank_next;
        hit_value_reg  <= hit_value_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        vic_found_reg  <= vic_found_next;
        vic_idx_reg    <= vic_idx_next;
        vic_cnt_reg    <= vic_cnt_next;
        vic_rank_reg   <= vic_rank_next;
        tgt_idx_reg    <= tgt_idx_next;
        evict_reg      <= evict_next;
        out_hit_reg    <= out_hit_next;
        out_value_reg  <= out_value_next;
    end

    assign m_valid = out_valid_reg;
    assign m_hit   = out_hit_reg;
    assign m_value = out_value_reg;

endmodule

`default_nettype wire

// ===== src/lfu_cache_lru_tiebreak.sv =====
// ----------------------------------------------------------------------------
// lfu_cache_lru_tiebreak: LFU key-value cache with LRU tie-break
// Fully associative store of CAPACITY entries, scanned by a small sequencer.
// ----------------------------------------------------------------------------
// Each request is a get (tuser = 0) or a put (tuser = 1) carrying a 32-bit key
// and value. A get returns one response: hit flag in tuser and the stored value
// in tdata, or all ones on a miss. A put returns nothing. A request walks the
// entry store through one read/write port: a lookup pass over all entries that
// finds the key, the first free slot and the eviction victim (lowest use count,
// oldest among equals), a decision step, and, when anything changes, a rewrite
// pass over all entries that updates ranks, counts and the new entry. A get
// miss or an ignored put skips the rewrite pass, and s_tready is high only
// between requests. A response waits in an output register, so the next request
// is taken while it is still pending. cfg_wdata sets how many entries may be
// used (values above CAPACITY act as CAPACITY, zero ignores puts); write it only
// while the block is idle. Reset clears all entries and sets the limit to 16.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_cache_lru_tiebreak
    import lfuc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    // request channel
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [63:0]      s_tdata,   // [31:0] key, [63:32] value
    input  wire logic [0:0]       s_tuser,   // [0] kind: 0 get, 1 put
    // response channel
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [31:0]           m_tdata,   // [31:0] read_value
    output logic [0:0]            m_tuser,   // [0] hit
    // configuration
    input  wire logic             cfg_we,
    input  wire logic [CFG_W-1:0] cfg_wdata  // entries_in_use
);

    logic [CFG_W-1:0] limit_reg;
    logic [IDX_W-1:0] rd_idx;
    entry_t           rd;
    store_wr_t        wr;

    // entry limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    lfuc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_kind    (s_tuser[0]),
        .s_key     (s_tdata[31:0]),
        .s_value   (s_tdata[63:32]),
        .cfg_limit (limit_reg),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_hit     (m_tuser[0]),
        .m_value   (m_tdata),
        .rd_idx    (rd_idx),
        .rd        (rd),
        .wr        (wr)
    );

    lfuc_store u_store
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_idx (rd_idx),
        .rd     (rd),
        .wr     (wr)
    );

endmodule

`default_nettype wire

// ===== tb/sv/lfu_cache_lru_tiebreak_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lfu_cache_lru_tiebreak_tb: self-checking bench for the LFU cache
// Streams get/put requests in bursts, mirrors the cache contents and checks
// every get response in order against the mirror.
// ----------------------------------------------------------------------------
// Flow: reset, a short directed run at the reset limit, then directed runs
// with a lowered limit (one victim per new put) and with the limit at zero.
// After those come random phases, each under its own limit; the extremes
// (0, 1, 16, 31) are all used. The limit is changed only with the cache idle.
//
// Driver and receiver work on the falling edge; the monitor samples on the
// rising edge, where it also advances the mirror for each accepted request.
// ----------------------------------------------------------------------------

module lfu_cache_lru_tiebreak_tb;

    import lfuc_pkg::*;

    // the settle time covers the longest request, with margin to spare
    localparam int REQ_CYCLES    = 2 * CAPACITY + 2;
    localparam int SETTLE_CYCLES = REQ_CYCLES + 16;
    localparam int CYCLE_LIMIT   = 500000;

    typedef struct packed {
        logic             kind;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] wdata;
    } cache_req_t;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] rdata;
    } lookup_t;

    // receiver back-pressure patterns
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_SPARSE,
        RX_BLOCKED
    } rx_mode_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [63:0]      s_tdata   = '0;   // [31:0] key, [63:32] value
    logic [0:0]       s_tuser   = '0;   // [0] kind
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [31:0]      m_tdata;          // [31:0] read_value
    logic [0:0]       m_tuser;          // [0] hit
    logic             cfg_we    = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;   // entries_in_use

    lfu_cache_lru_tiebreak dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // requests waiting to be sent, and get responses still owed by the cache
    cache_req_t pending_reqs [$];
    lookup_t    lookups_due  [$];

    int   mismatches  = 0;
    int   cycle_count = 0;
    logic req_fire    = 1'b0;   // request handshake seen at the last rising edge

    // ------------------------------------------------------------------------
    // Mirror of the cache: entries, use counts, recency ranks (0 = newest)
    // ------------------------------------------------------------------------
    logic                   ent_valid [CAPACITY];
    logic [KEY_W-1:0]       ent_key   [CAPACITY];
    logic [VAL_W-1:0]       ent_val   [CAPACITY];
    logic [COUNT_WIDTH-1:0] ent_count [CAPACITY];
    logic [IDX_W-1:0]       ent_rank  [CAPACITY];
    logic [OCC_W-1:0]       ent_occ;
    logic [CFG_W-1:0]       ent_limit;

    // A use: bump the count (saturating) and move the entry to the front.
    function automatic void ent_touch(input int e);
        for (int i = 0; i < CAPACITY; i++)
            if (ent_valid[i] && ent_rank[i] < ent_rank[e])
                ent_rank[i]++;
        ent_rank[e] = '0;
        if (ent_count[e] != COUNT_MAX)
            ent_count[e]++;
    endfunction

    // Advance the mirror by one accepted request; a get queues its response.
    function automatic void cache_apply(input cache_req_t rq);
        int      found;
        int      victim;
        int      free_slot;
        int      lim;
        lookup_t resp;
        found     = -1;
        victim    = -1;
        free_slot = -1;
        lim       = (ent_limit > CAPACITY) ? CAPACITY : int'(ent_limit);
        for (int i = 0; i < CAPACITY; i++)
            if (ent_valid[i] && ent_key[i] == rq.key)
                found = i;

        if (rq.kind == KIND_GET)
        begin
            if (found >= 0)
            begin
                resp.hit   = 1'b1;
                resp.rdata = ent_val[found];
                ent_touch(found);
            end
            else
            begin
                resp.hit   = 1'b0;
                resp.rdata = MISS_VALUE;
            end
            lookups_due.push_back(resp);
        end
        else if (lim != 0)
        begin
            if (found >= 0)
            begin
                ent_val[found] = rq.wdata;
                ent_touch(found);
            end
            else
            begin
                // full (or over a lowered limit): drop exactly one victim,
                // lowest count first, oldest among equal counts
                if (ent_occ >= lim)
                begin
                    for (int i = 0; i < CAPACITY; i++)
                        if (ent_valid[i] && (victim < 0 || ent_count[i] < ent_count[victim] ||
                            (ent_count[i] == ent_count[victim] &&
                             ent_rank[i] > ent_rank[victim])))
                            victim = i;
                    if (victim >= 0)
                    begin
                        for (int i = 0; i < CAPACITY; i++)
                            if (ent_valid[i] && ent_rank[i] > ent_rank[victim])
                                ent_rank[i]--;
                        ent_valid[victim] = 1'b0;
                        ent_occ--;
                    end
                end
                for (int i = 0; i < CAPACITY; i++)
                    if (!ent_valid[i] && free_slot < 0)
                        free_slot = i;
                if (free_slot >= 0)
                begin
                    for (int i = 0; i < CAPACITY; i++)
                        if (ent_valid[i])
                            ent_rank[i]++;
                    ent_valid[free_slot] = 1'b1;
                    ent_key[free_slot]   = rq.key;
                    ent_val[free_slot]   = rq.wdata;
                    ent_count[free_slot] = COUNT_WIDTH'(1);
                    ent_rank[free_slot]  = '0;
                    ent_occ++;
                end
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: response check, mirror update, limit tracking, watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        lookup_t want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("lfu_cache_lru_tiebreak_tb: done, errors");
            $finish;
        end

        if (!rst_n)
        begin
            for (int i = 0; i < CAPACITY; i++)
                ent_valid[i] = 1'b0;
            ent_occ   = '0;
            ent_limit = CFG_RESET;
            req_fire <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (lookups_due.size() == 0)
                begin
                    $display("%0t: response with no get outstanding: hit=%0d value=%h",
                             $time, m_tuser[0], m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = lookups_due.pop_front();
                    if (m_tuser[0] !== want.hit || m_tdata !== want.rdata)
                    begin
                        $display("%0t: get mismatch: expected hit=%0d value=%h, got hit=%0d value=%h",
                                 $time, want.hit, want.rdata, m_tuser[0], m_tdata);
                        mismatches++;
                    end
                end
            end

            // a response can never belong to a request taken on the same edge,
            // so checking before updating is safe
            if (s_tvalid && s_tready)
                cache_apply({s_tuser[0], s_tdata[31:0], s_tdata[63:32]});
            req_fire <= s_tvalid && s_tready;

            if (cfg_we)
                ent_limit = cfg_wdata;
        end
    end

    // ------------------------------------------------------------------------
    // Request driver: bursts with random gaps, now and then a full drain pause
    // ------------------------------------------------------------------------
    int   burst_left   = 4;
    int   gap_left     = 0;
    int   drain_pauses = 0;
    logic wait_drain   = 1'b0;

    always @(negedge clk)
    begin : driver
        cache_req_t rq;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (s_tvalid && !req_fire)
        begin
            // request still on the bus, hold it
        end
        else
        begin
            if (wait_drain && lookups_due.size() == 0)
                wait_drain = 1'b0;
            if (wait_drain || gap_left > 0 || pending_reqs.size() == 0)
            begin
                if (!wait_drain && gap_left > 0)
                    gap_left--;
                s_tvalid <= 1'b0;
            end
            else
            begin
                rq = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {rq.wdata, rq.key};
                s_tuser  <= rq.kind;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 12);
                    // a quarter of bursts run straight into the next one
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 48);
                    if (drain_pauses == 0 || $urandom_range(0, 9) == 0)
                    begin
                        wait_drain = 1'b1;
                        drain_pauses++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response receiver: stretches of open, random, sparse and blocked ready
    // ------------------------------------------------------------------------
    rx_mode_t rx_mode = RX_OPEN;
    int       rx_left = 0;

    always @(negedge clk)
    begin : receiver
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = (rx_mode == RX_BLOCKED) ? $urandom_range(1, 30) : $urandom_range(20, 200);
        end
        else
            rx_left--;
        case (rx_mode)
            RX_OPEN:   m_tready <= 1'b1;
            RX_RANDOM: m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
            default:   m_tready <= 1'b0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    function automatic void queue_req(input logic kind, input logic [KEY_W-1:0] key,
                                      input logic [VAL_W-1:0] wdata);
        cache_req_t rq;
        rq.kind  = kind;
        rq.key   = key;
        rq.wdata = wdata;
        pending_reqs.push_back(rq);
    endfunction

    // Wait until every request is sent and every response is back, then give
    // the cache time to finish a trailing put, which has no response.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_reqs.size() != 0 || s_tvalid || lookups_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_entry_limit(input logic [CFG_W-1:0] lim);
        wait_idle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= lim;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Keys come mostly from a small pool, skewed towards its head so that use
    // counts spread out and ties occur; the rest are extreme or fully random.
    task automatic queue_random_phase(input int n_items, input int pool_n);
        logic [KEY_W-1:0] pool [$];
        cache_req_t       rq;
        int               pick;
        for (int i = 0; i < pool_n; i++)
            pool.push_back($urandom);
        repeat (n_items)
        begin
            rq.kind = ($urandom_range(0, 1) == 1) ? KIND_PUT : KIND_GET;
            pick    = $urandom_range(0, 9);
            if (pick < 7)
                rq.key = pool[$urandom_range(0, $urandom_range(0, pool_n - 1))];
            else if (pick == 7)
                case ($urandom_range(0, 3))
                    0:       rq.key = '0;
                    1:       rq.key = 32'h7FFF_FFFF;
                    2:       rq.key = 32'h8000_0000;
                    default: rq.key = '1;
                endcase
            else
                rq.key = $urandom;
            rq.wdata = $urandom;
            pending_reqs.push_back(rq);
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset limit: miss on an empty cache, extreme keys and values,
        // hits, an update of a present key, a miss among stored keys
        queue_req(KIND_GET, 32'h0000_0000, 32'hDEAD_BEEF);
        queue_req(KIND_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_req(KIND_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_req(KIND_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_req(KIND_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_req(KIND_GET, 32'h8000_0000, 32'h0000_0000);
        queue_req(KIND_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        queue_req(KIND_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        queue_req(KIND_GET, 32'h0000_0000, 32'h0000_0000);
        queue_req(KIND_PUT, 32'h7FFF_FFFF, 32'h1234_5678);
        queue_req(KIND_GET, 32'h7FFF_FFFF, 32'h0000_0000);
        queue_req(KIND_GET, 32'h5A5A_5A5A, 32'h0000_0000);

        // limit below occupancy: each new key evicts one, oldest of the
        // least used first, then the fresh count-1 entry
        set_entry_limit(CFG_W'(2));
        queue_req(KIND_PUT, 32'h1111_1111, 32'h0000_0001);
        queue_req(KIND_PUT, 32'h2222_2222, 32'h0000_0002);
        queue_req(KIND_GET, 32'h8000_0000, 32'h0000_0000);
        queue_req(KIND_GET, 32'h1111_1111, 32'h0000_0000);
        queue_req(KIND_GET, 32'h2222_2222, 32'h0000_0000);

        // limit zero: puts ignored (even updates), gets still find old entries
        set_entry_limit(CFG_W'(0));
        queue_req(KIND_PUT, 32'h3333_3333, 32'h0000_0003);
        queue_req(KIND_GET, 32'h3333_3333, 32'h0000_0000);
        queue_req(KIND_PUT, 32'h7FFF_FFFF, 32'h0000_0000);
        queue_req(KIND_GET, 32'h7FFF_FFFF, 32'h0000_0000);

        // random phases; 31 and 17 exceed the store and act as full size
        set_entry_limit(CFG_W'(31));
        queue_random_phase(80, 20);
        set_entry_limit(CFG_W'(16));
        queue_random_phase(80, 24);
        set_entry_limit(CFG_W'(1));
        queue_random_phase(40, 4);
        set_entry_limit(CFG_W'(4));
        queue_random_phase(70, 8);
        set_entry_limit(CFG_W'(17));
        queue_random_phase(70, 20);
        set_entry_limit(CFG_W'(16));
        queue_random_phase(40, 16);
        // drop well below the occupancy just built up
        set_entry_limit(CFG_W'(3));
        queue_random_phase(60, 6);
        set_entry_limit(CFG_W'(0));
        queue_random_phase(30, 8);
        set_entry_limit(CFG_W'(8));
        queue_random_phase(80, 12);
        set_entry_limit(CFG_W'(16));
        queue_random_phase(50, 20);

        wait_idle();
        if (mismatches == 0)
            $display("lfu_cache_lru_tiebreak_tb: done, clean");
        else
            $display("lfu_cache_lru_tiebreak_tb: done, errors");
        $finish;
    end

endmodule
